// ----- design/hn_pkg.sv -----
// ----------------------------------------------------------------------------
// Histogram normalizer package
// Shared types and codes for the histogram normalizer.
// ----------------------------------------------------------------------------
package hn_pkg;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_FINAL = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO      = 2'd1;
  localparam logic [1:0] ST_NOT_FINAL = 2'd2;

  localparam int OUT_BITS = 28;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] pixel_value;
    logic [7:0] bin_index;
  } hn_in_t;

  typedef struct packed {
    logic [27:0] scaled_value;
    logic [7:0]  peak_bin;
    logic [1:0]  status;
  } hn_out_t;
endpackage

// ----- design/hn_if.sv -----
// ----------------------------------------------------------------------------
// Histogram normalizer channels
// Valid/ready channel carrying one transaction payload.
// ----------------------------------------------------------------------------
interface hn_in_if;
  import hn_pkg::*;
  logic   valid;
  logic   ready;
  hn_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hn_out_if;
  import hn_pkg::*;
  logic    valid;
  logic    ready;
  hn_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/histogram_normalizer.sv -----
// ----------------------------------------------------------------------------
// Histogram normalizer
// 256-bin pixel histogram with min/max finalize and scaled bin reads.
// ----------------------------------------------------------------------------
// One transaction at a time. Clear sweeps the bin memory and then replies.
// Add is a read-modify-write on the bin memory. Finalize scans all bins
// through one compare unit, one bin per cycle. Read fetches the bin and,
// after a finalize with a nonzero range, runs a one-bit-per-cycle divider.
// A result waits in the output register; the next item is taken once the
// result is gone. After reset the bins are swept clear before the first
// item is taken.
module histogram_normalizer #(
  parameter int COUNT_BITS = 20
) (
  input logic     clk,
  input logic     rst,
  hn_in_if.sink   in_ch,
  hn_out_if.source out_ch
);
  import hn_pkg::*;
  localparam int NUM_BITS = COUNT_BITS + 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_ARD = 4'd2,
    S_AWR = 4'd3, S_FRD = 4'd4, S_FSCAN = 4'd5, S_FCLIP = 4'd6,
    S_RRD = 4'd7, S_RDIV = 4'd8, S_OUT = 4'd9, S_RWAIT = 4'd10,
    S_FWAIT = 4'd11, S_AWAIT = 4'd12;

  logic [3:0] state;
  logic [COUNT_BITS-1:0] mem [256];
  logic [COUNT_BITS-1:0] rdata;
  logic [7:0] raddr, waddr, ptr;
  logic we;
  logic [COUNT_BITS-1:0] wdata;
  logic [8:0] cnt;
  logic reply;
  logic [COUNT_BITS-1:0] lo, hi, prev_hi, delta;
  logic [7:0] where, peak;
  logic fin;
  logic clip;
  hn_out_t res;
  logic div_start, div_done;
  logic [27:0] quo;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  hn_div #(.NUM_BITS(NUM_BITS), .DEN_BITS(COUNT_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({rdata, 8'd0}), .den(delta), .done(div_done), .quo(quo));

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = res;
  assign div_start    = (state == S_RWAIT);
  assign clip         = (hi - prev_hi) > prev_hi;

  always_comb begin
    raddr = ptr;
    if (state == S_IDLE) raddr = in_ch.data.operation == OP_READ ?
      in_ch.data.bin_index : in_ch.data.pixel_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      we <= 1'b0;
      state <= S_CLEAR;
      ptr <= '0;
      cnt <= '0;
      reply <= 1'b0;
      fin <= 1'b0;
      peak <= '0;
      delta <= '0;
    end else begin
      we <= (state == S_CLEAR) || (state == S_AWR) || (state == S_FCLIP && clip);
      case (state)
        S_CLEAR: begin
          waddr <= cnt[7:0];
          wdata <= '0;
          cnt <= cnt + 1'b1;
          if (cnt == 9'd255) state <= S_AWAIT;
        end
        // A sweep started by a clear transaction answers; the one after reset does not.
        S_AWAIT: state <= reply ? S_OUT : S_IDLE;
        S_IDLE: if (in_ch.valid) begin
          res <= '0;
          case (in_ch.data.operation)
            OP_CLEAR: begin
              fin <= 1'b0; peak <= '0; delta <= '0;
              cnt <= '0; reply <= 1'b1;
              state <= S_CLEAR;
            end
            OP_ADD: begin ptr <= raddr; fin <= 1'b0; state <= S_ARD; end
            OP_FINAL: begin ptr <= '0; state <= S_FRD; end
            default: begin ptr <= raddr; state <= S_RRD; end
          endcase
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          waddr <= ptr;
          wdata <= (rdata == COUNT_MAX) ? rdata : rdata + 1'b1;
          res.peak_bin <= peak;
          state <= S_OUT;
        end
        S_FRD: begin ptr <= 8'd1; state <= S_FWAIT; end
        S_FWAIT: begin
          lo <= rdata; hi <= rdata; prev_hi <= rdata; where <= '0;
          ptr <= 8'd2; cnt <= 9'd1;
          state <= S_FSCAN;
        end
        S_FSCAN: begin
          // rdata holds bin cnt; address ptr is in flight
          if (rdata < lo) lo <= rdata;
          if (rdata > hi) begin
            prev_hi <= hi; hi <= rdata; where <= cnt[7:0];
          end
          ptr <= ptr + 1'b1;
          cnt <= cnt + 1'b1;
          if (cnt == 9'd255) state <= S_FCLIP;
        end
        S_FCLIP: begin
          logic [COUNT_BITS-1:0] h;
          h = hi;
          if (clip) begin
            waddr <= where; wdata <= prev_hi; h = prev_hi;
          end
          delta <= h - lo;
          peak <= where;
          fin <= 1'b1;
          res.peak_bin <= where;
          res.scaled_value <= (NUM_BITS - 8 > OUT_BITS &&
            ({{(32-COUNT_BITS){1'b0}}, h - lo} >> OUT_BITS) != 0) ? '1 :
            OUT_BITS'(h - lo);
          res.status <= (h == lo) ? ST_ZERO : ST_OK;
          state <= S_OUT;
        end
        S_RRD: begin
          res.peak_bin <= peak;
          if (!fin) begin res.status <= ST_NOT_FINAL; state <= S_OUT; end
          else if (delta == '0) begin res.status <= ST_ZERO; state <= S_OUT; end
          else state <= S_RWAIT;
        end
        S_RWAIT: state <= S_RDIV;
        S_RDIV: if (div_done) begin
          res.scaled_value <= quo;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- design/hn_div.sv -----
// ----------------------------------------------------------------------------
// Histogram normalizer divider
// Restoring divider, one quotient bit per cycle, quotient clamped to 28 bits.
// ----------------------------------------------------------------------------
module hn_div #(
  parameter int NUM_BITS = 28,
  parameter int DEN_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [27:0]         quo
);
  import hn_pkg::*;
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q;
  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS-1:0] dv;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [DEN_BITS:0]   trial;

  assign trial = {rem[DEN_BITS-1:0], q[NUM_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      q    <= num;
      dv   <= den;
      rem  <= '0;
      cnt  <= CNT_BITS'(NUM_BITS);
      done <= 1'b0;
    end else if (busy) begin
      if (trial >= {1'b0, dv}) begin
        rem <= trial - {1'b0, dv};
        q   <= {q[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NUM_BITS-2:0], 1'b0};
      end
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_BITS'(1));
      done <= (cnt == CNT_BITS'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_comb begin
    if (NUM_BITS > OUT_BITS && (q >> OUT_BITS) != '0) quo = '1;
    else quo = OUT_BITS'(q);
  end
endmodule

// ----- design/hn_checker.sv -----
// ----------------------------------------------------------------------------
// Histogram normalizer checker
// Port-level properties of the normalizer, bound onto the top level.
// ----------------------------------------------------------------------------
module hn_props (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status,
  input logic [27:0] scaled_value
);
  import hn_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_no_result_next: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");
  a_zero_scaled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> scaled_value == '0)
    else $error("nonzero value with error status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind histogram_normalizer hn_props u_hn_props (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.data.status), .scaled_value(out_ch.data.scaled_value));

// ----- tb/sv/hn_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The channel interfaces come from the design; this file holds the shared
// random gap helper used by the stimulus and the result sink.
// ----------------------------------------------------------------------------
package hn_tb_pkg;
  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(10, 60);
  endfunction
endpackage

// ----- tb/sv/hn_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Histogram normalizer checker
// Watches both channels, keeps a shadow histogram, predicts every result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module hn_checker #(
  parameter int COUNT_BITS = 20
) (
  input  logic       clk,
  input  logic       rst,
  hn_in_if.sink      in_mon,
  hn_out_if.sink     out_mon,
  output int         fail_count,
  output int         pending
);
  import hn_pkg::*;

  localparam logic [COUNT_BITS-1:0] BIN_MAX = '1;
  localparam logic [27:0] SCALED_MAX = '1;

  logic [COUNT_BITS-1:0] shadow_bins [256];
  logic [COUNT_BITS-1:0] shadow_delta;
  logic [7:0]            shadow_peak;
  logic                  shadow_final;
  hn_out_t               expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [27:0] sat28(logic [63:0] v);
    return (v > 64'(SCALED_MAX)) ? SCALED_MAX : v[27:0];
  endfunction

  function automatic void histogram_finalize();
    logic [COUNT_BITS-1:0] lo, hi, prev_hi, c;
    logic [7:0] where;
    lo = shadow_bins[0];
    hi = shadow_bins[0];
    prev_hi = shadow_bins[0];
    where = '0;
    for (int k = 1; k < 256; k++) begin
      c = shadow_bins[k];
      if (c < lo) lo = c;
      if (c > hi) begin
        prev_hi = hi;
        where = 8'(k);
        hi = c;
      end
    end
    if (hi - prev_hi > prev_hi) begin
      shadow_bins[where] = prev_hi;
      hi = prev_hi;
    end
    shadow_delta = hi - lo;
    shadow_peak = where;
    shadow_final = 1'b1;
  endfunction

  function automatic hn_out_t predict_histogram(hn_in_t t);
    hn_out_t r;
    r = '0;
    case (t.operation)
      OP_CLEAR: begin
        foreach (shadow_bins[k]) shadow_bins[k] = '0;
        shadow_delta = '0;
        shadow_peak = '0;
        shadow_final = 1'b0;
      end
      OP_ADD: begin
        if (shadow_bins[t.pixel_value] != BIN_MAX)
          shadow_bins[t.pixel_value] = shadow_bins[t.pixel_value] + 1'b1;
        shadow_final = 1'b0;
      end
      OP_FINAL: begin
        histogram_finalize();
        r.scaled_value = sat28(64'(shadow_delta));
        r.status = (shadow_delta == 0) ? ST_ZERO : ST_OK;
      end
      default: begin
        if (!shadow_final) r.status = ST_NOT_FINAL;
        else if (shadow_delta == 0) r.status = ST_ZERO;
        else r.scaled_value =
          sat28((64'(shadow_bins[t.bin_index]) << 8) / 64'(shadow_delta));
      end
    endcase
    r.peak_bin = shadow_peak;
    return r;
  endfunction

  always @(posedge clk) begin
    hn_out_t exp_r;
    if (rst) begin
      foreach (shadow_bins[k]) shadow_bins[k] = '0;
      shadow_delta = '0;
      shadow_peak = '0;
      shadow_final = 1'b0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_mon.data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== out_mon.data) begin
            $display("%0t: mismatch expected scaled=%0d peak=%0d status=%0d,",
                     $time, exp_r.scaled_value, exp_r.peak_bin, exp_r.status,
                     " actual scaled=%0d peak=%0d status=%0d",
                     out_mon.data.scaled_value, out_mon.data.peak_bin,
                     out_mon.data.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Prediction uses blocking updates, so the next transaction sees the new shadow state.
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_histogram(in_mon.data));
    end
  end
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Histogram normalizer testbench
// Drives directed and random histogram sessions (clear, adds, finalize,
// reads) with random idling on both channels; a checker compares results.
// ----------------------------------------------------------------------------
module testbench;
  import hn_pkg::*;
  import hn_tb_pkg::*;

  localparam int COUNT_BITS = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  bit   stim_done = 1'b0;

  hn_in_if  in_ch ();
  hn_out_if out_ch ();

  always #5 clk = ~clk;

  histogram_normalizer #(.COUNT_BITS(COUNT_BITS)) u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  hn_checker #(.COUNT_BITS(COUNT_BITS)) u_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stalls, with an occasional stretch of full speed.
  initial begin
    int unsigned gap;
    int unsigned burst;
    burst = 0;
    @(posedge clk iff !rst);
    forever begin
      if (burst == 0 && $urandom_range(0, 19) == 0) burst = $urandom_range(20, 200);
      gap = (burst > 0) ? 0 : pick_gap();
      if (burst > 0) burst--;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  bit no_gaps = 1'b0;

  task automatic send_op(logic [1:0] op, logic [7:0] pix, logic [7:0] idx);
    int unsigned gap;
    hn_in_t t;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    t.operation = op;
    t.pixel_value = pix;
    t.bin_index = idx;
    in_ch.data <= t;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Clear, adds with a random peak shape, finalize and reads, plus an occasional early read or late add and read.
  task automatic histogram_session(int unsigned adds);
    int unsigned shape;
    logic [7:0] hot;
    logic [7:0] p;
    shape = $urandom_range(0, 3);
    hot = 8'($urandom);
    send_op(OP_CLEAR, 8'($urandom), 8'($urandom));
    for (int unsigned i = 0; i < adds; i++) begin
      case (shape)
        0: p = 8'($urandom);
        1: p = ($urandom_range(0, 1) != 0) ? hot : 8'($urandom);
        2: p = hot ^ 8'($urandom_range(0, 3));
        default: p = 8'($urandom_range(0, 7));
      endcase
      send_op(OP_ADD, p, 8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) send_op(OP_READ, 8'($urandom), 8'($urandom));
    send_op(OP_FINAL, 8'($urandom), 8'($urandom));
    repeat ($urandom_range(2, 8)) begin
      p = ($urandom_range(0, 2) == 0) ? hot : 8'($urandom);
      send_op(OP_READ, 8'($urandom), p);
    end
    if ($urandom_range(0, 5) == 0) begin
      send_op(OP_ADD, hot, 8'($urandom));
      send_op(OP_READ, 8'($urandom), hot);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads before finalize, zero-delta histograms, extremes, clipping.
    send_op(OP_READ, 8'h00, 8'hFF);
    send_op(OP_FINAL, 8'hFF, 8'h00);
    send_op(OP_READ, 8'hFF, 8'h00);
    send_op(OP_ADD, 8'hFF, 8'h00);
    send_op(OP_READ, 8'h00, 8'hFF);
    send_op(OP_FINAL, 8'h00, 8'h00);
    send_op(OP_READ, 8'h00, 8'hFF);
    send_op(OP_READ, 8'h00, 8'h00);
    send_op(OP_ADD, 8'h00, 8'hFF);
    send_op(OP_ADD, 8'h80, 8'h00);
    send_op(OP_ADD, 8'h80, 8'h00);
    send_op(OP_ADD, 8'h80, 8'h00);
    send_op(OP_ADD, 8'h7F, 8'h00);
    send_op(OP_FINAL, 8'h00, 8'h00);
    send_op(OP_READ, 8'h00, 8'h80);
    send_op(OP_READ, 8'h00, 8'h7F);
    send_op(OP_READ, 8'h00, 8'h55);
    send_op(OP_CLEAR, 8'hAA, 8'h55);
    send_op(OP_READ, 8'h00, 8'h80);
    send_op(OP_FINAL, 8'h00, 8'h00);

    // Pause with the pipeline fully drained, then run at full rate for a while.
    idle_until_drained();
    no_gaps = 1'b1;
    histogram_session(30);
    no_gaps = 1'b0;

    sent = 0;
    while (sent < 850) begin
      if ($urandom_range(0, 9) == 0) begin
        send_op(2'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end else begin
        n = $urandom_range(0, 9) == 0 ? $urandom_range(40, 90) : $urandom_range(1, 25);
        histogram_session(n);
        sent += n + 6;
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0)
      $display("histogram_normalizer test passed");
    else
      $display("histogram_normalizer test failed");
    $finish;
  end

  // Watchdog for the worst-case run, long stalls included.
  initial begin
    #20ms;
    $display("histogram_normalizer test failed");
    $finish;
  end
endmodule
